// File: rtl/core/fcpp_pkg.sv
// Package for the framed command packet parser core.
// Holds the parse phase enum, register indexes, status codes and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcpp_pkg;

  // Parse phases; codes above PH_CHECK act as hunting
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  // Configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // Reset values of the sync registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAF;

  // Result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Frame end status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [4:0] index;
    logic [7:0] command;
    logic [7:0] length;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/framed_command_packet_parser_core.sv
// Framed command packet parser: sync hunt, header capture, payload tagging
// and additive checksum check. Depends on fcpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Results are registered: each result enters the output buffer when its byte is accepted.
// Throughput: one byte per cycle while the skid entry is empty; the phase and
// checksum update is a short 8-bit sum (four terms at the length byte) and
// compare done in the accept cycle. A two-entry output buffer (output register
// plus skid) keeps bytes flowing for one extra result while the sink stalls.
// Reset (rst_ni low, asynchronous) returns to hunting, empties the output
// buffer and loads the sync registers with 0xAA and 0xAF.
module framed_command_packet_parser_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  // input beats
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  // result beats
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [4:0]      payload_index_o,
  output logic [7:0]      frame_command_o,
  output logic [7:0]      frame_length_o,
  output logic [1:0]      frame_status_o
);
  import fcpp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Configuration registers
  logic [7:0] sync_first_q, sync_second_q;

  // Parser state
  phase_e           phase_q, phase_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;

  // Output buffer
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid;
  logic    accept, pop;

  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       cnt_ext;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign cnt_ext    = 8'(cnt_q);

  // Write sync registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default:         sync_first_q  <= sync_first_q;
      endcase
    end
  end

  // Next phase, header capture, checksum and result for the accepted beat
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    res_valid = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.pbyte   = 8'd0;
    res.index   = 5'd0;
    res.command = cmd_q;
    res.length  = len_q;
    res.status  = STATUS_OK;
    unique case (phase_q)
      PH_SYNC1: begin
        phase_d = (rx_byte_i == sync_second_q) ? PH_CMD : PH_HUNT;
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d      = rx_byte_i;
        cnt_d      = '0;
        res.length = rx_byte_i;
        if (rx_byte_i > MAX_LEN) begin
          phase_d    = PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = KIND_FRAME_END;
          res.status = STATUS_TOO_LONG;
        end else begin
          sum_d   = sync_first_q + sync_second_q + cmd_q + rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_d     = sum_q + rx_byte_i;
        cnt_d     = cnt_inc;
        res_valid = 1'b1;
        res.pbyte = rx_byte_i;
        res.index = cnt_ext[4:0];
        if (8'(cnt_inc) >= len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_d    = PH_HUNT;
        res_valid  = 1'b1;
        res.kind   = KIND_FRAME_END;
        res.status = (rx_byte_i == sum_q) ? STATUS_OK : STATUS_BAD_SUM;
      end
      default: begin
        phase_d = (rx_byte_i == sync_first_q) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  // Output register and skid: drain skid first, park a new result when stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign payload_byte_o  = out_q.pbyte;
  assign payload_index_o = out_q.index;
  assign frame_command_o = out_q.command;
  assign frame_length_o  = out_q.length;
  assign frame_status_o  = out_q.status;

  // Skid only fills behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // Payload count stays below the declared length while in data
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (8'(cnt_q) < len_q))
    else $error("payload count reached length inside data phase");

  // Data phase is only entered with a legal nonzero length
  a_len_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (len_q != 8'd0 && len_q <= MAX_LEN))
    else $error("data phase with illegal length");

  // Payload results never carry a frame status
  a_payload_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_PAYLOAD) |-> (out_q.status == STATUS_OK))
    else $error("payload result with nonzero status");

  // A length error leaves the parser hunting
  a_too_long_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_LEN && rx_byte_i > MAX_LEN) |=> (phase_q == PH_HUNT))
    else $error("parser not hunting after length error");

endmodule

`default_nettype wire
